/* rtl/core/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types and constants for the pixel format converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

    typedef enum logic [1:0] {
        FMT_PALETTE = 2'd0,
        FMT_RGB555  = 2'd1,
        FMT_RGB24   = 2'd2,
        FMT_RGB32   = 2'd3
    } fmt_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_FORMAT    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_PAD_BYTES = 4'd3;

    localparam int CFG_DATA_W = 13;
    localparam int ROW_W      = 13;
    localparam int PAD_W      = 8;

    localparam int DEFAULT_MAX_ROW_PIXELS = 4096;
    localparam logic [PAD_W-1:0] PAD_LIMIT = 8'd252;

    typedef struct packed {
        fmt_t             source_format;
        fmt_t             dest_format;
        logic [ROW_W-1:0] row_pixels;
        logic [PAD_W-1:0] dest_pad_bytes;
    } cfg_t;

endpackage

/* rtl/core/pfc_convert.sv */
// ----------------------------------------------------------------------------
// pfc_convert
// Single pass pixel conversion between palette, 5:5:5, 24-bit and 32-bit.
// ----------------------------------------------------------------------------
module pfc_convert
(
    input  pfc_pkg::fmt_t source_format,
    input  pfc_pkg::fmt_t dest_format,
    input  logic [31:0]   source_pixel,
    output logic [31:0]   word,
    output logic [2:0]    count
);

    localparam logic [7:0] LEVELS [6] = '{8'h00, 8'h33, 8'h66, 8'h99, 8'hCC, 8'hFF};
    localparam logic [7:0] NEAR_LIMIT = 8'd25;

    // first cube level within the limit
    function automatic logic [2:0] near_level(input logic [7:0] c);
        logic [2:0] k;
        logic       found;
        logic [7:0] d;
        k     = 3'd0;
        found = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            d = (c >= LEVELS[i]) ? (c - LEVELS[i]) : (LEVELS[i] - c);
            if (!found && d <= NEAR_LIMIT)
            begin
                k     = 3'(i);
                found = 1'b1;
            end
        end
        return k;
    endfunction

    logic [7:0] idx;
    logic [2:0] q36;
    logic [5:0] r36;
    logic [2:0] q6;
    logic [2:0] r6;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] alpha;
    logic [2:0] k0;
    logic [2:0] k1;
    logic [2:0] k2;

    // palette index split into base-6 digits
    always_comb
    begin
        idx = source_pixel[7:0];
        q36 = 3'd0;
        for (int i = 1; i < 6; i++)
        begin
            if (idx >= 8'(36 * i))
                q36 = 3'(i);
        end
        r36 = 6'(idx - 8'(q36) * 8'd36);
        q6  = 3'd0;
        for (int i = 1; i < 6; i++)
        begin
            if (r36 >= 6'(6 * i))
                q6 = 3'(i);
        end
        r6 = 3'(r36 - 6'(q6) * 6'd6);
    end

    always_comb
    begin
        alpha = 8'hFF;
        case (source_format)
            pfc_pkg::FMT_PALETTE:
            begin
                if (idx >= 8'd216)
                begin
                    c0 = 8'hFF;
                    c1 = 8'hFF;
                    c2 = 8'hFF;
                end
                else
                begin
                    c0 = LEVELS[q36];
                    c1 = LEVELS[q6];
                    c2 = LEVELS[r6];
                end
            end
            pfc_pkg::FMT_RGB555:
            begin
                c0 = {source_pixel[4:0], 3'b000};
                c1 = {source_pixel[9:5], 3'b000};
                c2 = {source_pixel[14:10], 3'b000};
            end
            pfc_pkg::FMT_RGB24:
            begin
                c0 = source_pixel[7:0];
                c1 = source_pixel[15:8];
                c2 = source_pixel[23:16];
            end
            default:
            begin
                c0    = source_pixel[7:0];
                c1    = source_pixel[15:8];
                c2    = source_pixel[23:16];
                alpha = source_pixel[31:24];
            end
        endcase
    end

    assign k0 = near_level(c0);
    assign k1 = near_level(c1);
    assign k2 = near_level(c2);

    always_comb
    begin
        count = {1'b0, dest_format} + 3'd1;
        if (source_format == dest_format)
        begin
            case (dest_format)
                pfc_pkg::FMT_PALETTE: word = {24'd0, source_pixel[7:0]};
                pfc_pkg::FMT_RGB555:  word = {16'd0, source_pixel[15:0]};
                pfc_pkg::FMT_RGB24:   word = {8'd0, source_pixel[23:0]};
                default:              word = source_pixel;
            endcase
        end
        else
        begin
            case (dest_format)
                pfc_pkg::FMT_PALETTE:
                    word = {24'd0, 8'(8'(k0) * 8'd36 + 8'(k1) * 8'd6 + 8'(k2))};
                pfc_pkg::FMT_RGB555:
                    word = {17'd0, c2[7:3], c1[7:3], c0[7:3]};
                pfc_pkg::FMT_RGB24:
                    word = {8'd0, c2, c1, c0};
                default:
                    word = {alpha, c2, c1, c0};
            endcase
        end
    end

endmodule

/* rtl/core/pfc_stream.sv */
// ----------------------------------------------------------------------------
// pfc_stream
// Input register, column counter, result register and row-end pad sequencer.
// ----------------------------------------------------------------------------
module pfc_stream
#(
    parameter int MAX_ROW_PIXELS = pfc_pkg::DEFAULT_MAX_ROW_PIXELS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  pfc_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [31:0]   source_pixel,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [31:0]   out_bytes,
    output logic [2:0]    out_count,
    output logic          last_of_run
);

    localparam int CW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
    localparam int RW = (CW + 1 > pfc_pkg::ROW_W) ? CW + 1 : pfc_pkg::ROW_W;
    localparam logic [RW-1:0] ROW_MAX = RW'(MAX_ROW_PIXELS);

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic [31:0]   s1_pixel_reg;
    logic [31:0]   s1_pixel_next;
    logic          s1_row_end_reg;
    logic          s1_row_end_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [31:0]   out_bytes_reg;
    logic [31:0]   out_bytes_next;
    logic [2:0]    out_count_reg;
    logic [2:0]    out_count_next;
    logic          last_reg;
    logic          last_next;
    logic [pfc_pkg::PAD_W-1:0] pad_left_reg;
    logic [pfc_pkg::PAD_W-1:0] pad_left_next;

    logic [RW-1:0] row_eff;
    logic [RW-1:0] row_in;
    logic          row_end;
    logic [pfc_pkg::PAD_W-1:0] pad_sat;
    logic [2:0]    pad_take;
    logic [pfc_pkg::PAD_W-1:0] pad_rest;
    logic          out_take;
    logic          pad_step;
    logic          load_out;
    logic          in_take;
    logic [31:0]   conv_word;
    logic [2:0]    conv_count;

    pfc_convert u_convert
    (
        .source_format (cfg.source_format),
        .dest_format   (cfg.dest_format),
        .source_pixel  (s1_pixel_reg),
        .word          (conv_word),
        .count         (conv_count)
    );

    // effective row length: zero reads as one, saturate at the maximum
    always_comb
    begin
        row_in = RW'(cfg.row_pixels);
        if (row_in == '0)
            row_eff = RW'(1);
        else if (row_in > ROW_MAX)
            row_eff = ROW_MAX;
        else
            row_eff = row_in;
        row_end = (RW'(col_reg) + RW'(1)) >= row_eff;
        pad_sat = (cfg.dest_pad_bytes > pfc_pkg::PAD_LIMIT) ? pfc_pkg::PAD_LIMIT
                                                            : cfg.dest_pad_bytes;
    end

    always_comb
    begin
        pad_take = (pad_left_reg > 8'd4) ? 3'd4 : pad_left_reg[2:0];
        pad_rest = pad_left_reg - pfc_pkg::PAD_W'(pad_take);
        out_take = out_valid_reg && !out_stall;
        pad_step = out_take && (pad_left_reg != '0);
        load_out = s1_valid_reg && (!out_valid_reg || (out_take && pad_left_reg == '0));
        in_stall = s1_valid_reg && !load_out;
        in_take  = in_valid && !in_stall;
    end

    always_comb
    begin
        col_next        = col_reg;
        s1_valid_next   = s1_valid_reg;
        s1_pixel_next   = s1_pixel_reg;
        s1_row_end_next = s1_row_end_reg;
        if (in_take)
        begin
            s1_valid_next   = 1'b1;
            s1_pixel_next   = source_pixel;
            s1_row_end_next = row_end;
            col_next        = row_end ? '0 : col_reg + CW'(1);
        end
        else if (load_out)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_bytes_next = out_bytes_reg;
        out_count_next = out_count_reg;
        last_next      = last_reg;
        pad_left_next  = pad_left_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_bytes_next = conv_word;
            out_count_next = conv_count;
            pad_left_next  = s1_row_end_reg ? pad_sat : '0;
            last_next      = !(s1_row_end_reg && pad_sat != '0);
        end
        else if (pad_step)
        begin
            out_bytes_next = '0;
            out_count_next = pad_take;
            pad_left_next  = pad_rest;
            last_next      = (pad_rest == '0);
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pad_left_reg  <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            pad_left_reg  <= pad_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pixel_reg   <= s1_pixel_next;
        s1_row_end_reg <= s1_row_end_next;
        out_bytes_reg  <= out_bytes_next;
        out_count_reg  <= out_count_next;
        last_reg       <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_bytes   = out_bytes_reg;
    assign out_count   = out_count_reg;
    assign last_of_run = last_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    a_not_last_has_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (pad_left_reg != '0))
        else $error("non-final result with no pad bytes left");

    a_last_no_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (pad_left_reg == '0))
        else $error("final result while pad bytes remain");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        RW'(col_reg) < ROW_MAX)
        else $error("column counter beyond maximum row length");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg >= 3'd1 && out_count_reg <= 3'd4))
        else $error("result byte count out of range");
`endif

endmodule

/* rtl/core/pixel_format_converter_top.sv */
// ----------------------------------------------------------------------------
// pixel_format_converter_top
// Pixel format converter with row-end zero padding and a register write port.
// ----------------------------------------------------------------------------
// Pipeline: a request passes the input register, then the result register.
// Throughput: one pixel per cycle unless out_stall; a row end adds pad results
//   of up to four zero bytes each, produced from the result register.
// Reset: registers return to palette/palette, row length 1, no padding;
//   column counter cleared, pipeline empty.
// ----------------------------------------------------------------------------
module pixel_format_converter_top
#(
    parameter int MAX_ROW_PIXELS = pfc_pkg::DEFAULT_MAX_ROW_PIXELS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [31:0]                    source_pixel,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [31:0]                    out_bytes,
    output logic [2:0]                     out_count,
    output logic                           last_of_run
);

    pfc_pkg::cfg_t cfg_reg;
    pfc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                pfc_pkg::REG_SOURCE_FORMAT:
                    cfg_next.source_format = pfc_pkg::fmt_t'(cfg_data[1:0]);
                pfc_pkg::REG_DEST_FORMAT:
                    cfg_next.dest_format = pfc_pkg::fmt_t'(cfg_data[1:0]);
                pfc_pkg::REG_ROW_PIXELS:
                    cfg_next.row_pixels = cfg_data[pfc_pkg::ROW_W-1:0];
                pfc_pkg::REG_DEST_PAD_BYTES:
                    cfg_next.dest_pad_bytes = cfg_data[pfc_pkg::PAD_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_format  <= pfc_pkg::FMT_PALETTE;
            cfg_reg.dest_format    <= pfc_pkg::FMT_PALETTE;
            cfg_reg.row_pixels     <= pfc_pkg::ROW_W'(1);
            cfg_reg.dest_pad_bytes <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pfc_stream
    #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    )
    u_stream
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .source_pixel (source_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_bytes    (out_bytes),
        .out_count    (out_count),
        .last_of_run  (last_of_run)
    );

endmodule
